[design/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg: shared definitions for the sorted table binary search core
// Widths, result status codes, request codes and the probe step flags.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int TableDepthDefault = 1024;
	localparam int KeyW              = 32;
	localparam int StatusW           = 2;
	localparam int IndexW            = 10;

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	localparam logic [StatusW-1:0] STATUS_APPENDED = 2'd0;
	localparam logic [StatusW-1:0] STATUS_FULL     = 2'd1;
	localparam logic [StatusW-1:0] STATUS_FOUND    = 2'd2;
	localparam logic [StatusW-1:0] STATUS_MISSING  = 2'd3;

	// Outcome of one probe of the search.
	typedef struct packed {
		logic hit;        // probed key equals the searched key
		logic exhausted;  // no match and the search window is now empty
	} step_flags_t;

endpackage

[design/stbs_probe_step.sv]
// ----------------------------------------------------------------------------
// stbs_probe_step: one binary search probe
// Compares the probed key with the target and narrows the half-open window
// [left, hi), then forms the midpoint of the narrowed window.
// ----------------------------------------------------------------------------
module stbs_probe_step #(
	parameter int AW = 10,
	parameter int CW = 11
) (
	input  logic [CW-1:0]                   left,
	input  logic [CW-1:0]                   hi,
	input  logic [AW-1:0]                   mid,
	input  logic signed [stbs_pkg::KeyW-1:0] probe,
	input  logic signed [stbs_pkg::KeyW-1:0] target,
	output stbs_pkg::step_flags_t           flags,
	output logic [CW-1:0]                   next_left,
	output logic [CW-1:0]                   next_hi,
	output logic [AW-1:0]                   next_mid
);

	logic          go_right;
	logic [CW-1:0] mid_ext;
	logic [CW-1:0] span_half;

	assign mid_ext  = CW'(mid);
	assign go_right = probe < target;

	// Probe below the target moves the window above mid, otherwise below it.
	assign next_left = go_right ? (mid_ext + CW'(1)) : left;
	assign next_hi   = go_right ? hi : mid_ext;

	assign flags.hit       = (probe == target);
	assign flags.exhausted = !flags.hit && !(next_left < next_hi);

	// Same midpoint as left + floor((right - left) / 2) with right = hi - 1.
	assign span_half = (next_hi - next_left - CW'(1)) >> 1;
	assign next_mid  = AW'(next_left + span_half);

endmodule

[design/sorted_table_binary_search_core.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core: append-only key table with binary search
// Keys are appended to a synchronous memory; searches walk it one
// probe per cycle using the registered read data of the previous probe.
// ----------------------------------------------------------------------------
// Sequencing: an accepted request's result is held in ST_DONE and then
//   loaded into the output register once it is free; a search first walks
//   its probes in ST_SEARCH. A search needs at most ceil(log2(count + 1))
//   probes, 11 for a full 1024-entry table.
// Requests: one at a time; the next request is taken only once the last
//   result has been loaded into the output register. A stalled result holds
//   the core until it can be loaded.
// Reset: arst_n clears the control state and the entry count at once; table
//   contents are left undefined and are never read before being written.
module sorted_table_binary_search_core #(
	parameter int TABLE_DEPTH = stbs_pkg::TableDepthDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic signed [stbs_pkg::KeyW-1:0]    key,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [stbs_pkg::StatusW-1:0]        status,
	output logic [stbs_pkg::IndexW-1:0]         index
);

	// Address width covers the slots; count width also holds TABLE_DEPTH.
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	logic [1:0] state_q;
	logic [CW-1:0] count_q;

	// Search window and target.
	logic [CW-1:0] left_q;
	logic [CW-1:0] hi_q;
	logic [AW-1:0] mid_q;
	logic signed [stbs_pkg::KeyW-1:0] target_q;

	// Result waiting to move into the output register.
	logic [stbs_pkg::StatusW-1:0] res_status_q;
	logic [stbs_pkg::IndexW-1:0]  res_index_q;

	// Key table: one write port for appends, one registered read port for probes.
	logic signed [stbs_pkg::KeyW-1:0] key_mem [TABLE_DEPTH];
	logic signed [stbs_pkg::KeyW-1:0] rd_data_q;
	logic                             wr_en;
	logic                             rd_en;
	logic [AW-1:0]                    rd_addr;

	logic                  in_xfer;
	logic                  out_free;
	logic                  table_full;
	logic [AW-1:0]         first_mid;
	stbs_pkg::step_flags_t step_flags;
	logic [CW-1:0]         step_left;
	logic [CW-1:0]         step_hi;
	logic [AW-1:0]         step_mid;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign out_free   = !out_valid || out_ready;
	assign table_full = (count_q == CW'(TABLE_DEPTH));

	// First probe of a search sits in the middle of [0, count).
	assign first_mid = AW'((count_q - CW'(1)) >> 1);

	stbs_probe_step #(
		.AW(AW),
		.CW(CW)
	) u_step (
		.left      (left_q),
		.hi        (hi_q),
		.mid       (mid_q),
		.probe     (rd_data_q),
		.target    (target_q),
		.flags     (step_flags),
		.next_left (step_left),
		.next_hi   (step_hi),
		.next_mid  (step_mid)
	);

	// A request is finished before the next is taken, so a read never targets
	// an entry that is being written in the same cycle.
	assign wr_en = in_xfer && (req_type == stbs_pkg::REQ_APPEND) && !table_full;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = first_mid;
		if (state_q == ST_IDLE) begin
			rd_en = in_xfer && (req_type == stbs_pkg::REQ_SEARCH) && (count_q != '0);
		end else if (state_q == ST_SEARCH) begin
			rd_en   = !step_flags.hit && !step_flags.exhausted;
			rd_addr = step_mid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[count_q[AW-1:0]] <= key;
		end
		if (rd_en) begin
			rd_data_q <= key_mem[rd_addr];
		end
	end

	// Window and target registers carry no reset; they are loaded on every accepted request.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			target_q <= key;
			left_q   <= '0;
			hi_q     <= count_q;
			mid_q    <= first_mid;
		end else if (state_q == ST_SEARCH) begin
			left_q <= step_left;
			hi_q   <= step_hi;
			mid_q  <= step_mid;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_xfer) begin
			if (req_type == stbs_pkg::REQ_APPEND) begin
				res_status_q <= table_full ? stbs_pkg::STATUS_FULL : stbs_pkg::STATUS_APPENDED;
				res_index_q  <= table_full ? '0 : stbs_pkg::IndexW'(count_q);
			end else begin
				res_status_q <= stbs_pkg::STATUS_MISSING;
				res_index_q  <= '0;
			end
		end else if (state_q == ST_SEARCH && step_flags.hit) begin
			res_status_q <= stbs_pkg::STATUS_FOUND;
			res_index_q  <= stbs_pkg::IndexW'(mid_q);
		end
	end

	// Control: request sequencing, entry count and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
			status    <= '0;
			index     <= '0;
		end else begin
			// The output register empties on a transfer, unless a new result
			// is loaded into it at the same edge.
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						// An empty table answers a search without any probe.
						if (req_type == stbs_pkg::REQ_SEARCH && count_q != '0) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SEARCH: begin
					// A miss with an emptied window keeps the not-found result.
					if (step_flags.hit || step_flags.exhausted) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						status    <= res_status_q;
						index     <= res_index_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/stbs_checker.sv]
// ----------------------------------------------------------------------------
// stbs_checker: port-level checks for the sorted table binary search core
// Tracks requests in flight and checks result ordering and result encoding.
// ----------------------------------------------------------------------------
module stbs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         req_type,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [stbs_pkg::StatusW-1:0] status,
	input logic [stbs_pkg::IndexW-1:0]  index
);

	logic in_xfer;
	logic out_xfer;
	logic [1:0] pending_q;
	logic pending_req_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// Requests taken whose results have not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_xfer} - {1'b0, out_xfer};
		end
	end

	// Kind of the most recent request, used to match the next result.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pending_req_q <= req_type;
		end
	end

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (pending_q != 2'd0))
		else $error("result transferred with no request outstanding");

	a_bounded_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 2'd2) |-> !in_ready)
		else $error("request accepted while two are already outstanding");

	a_zero_index_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == stbs_pkg::STATUS_FULL || status == stbs_pkg::STATUS_MISSING)
		|-> (index == '0))
		else $error("dropped append or missed search reports a nonzero index");

	// With a single request outstanding, a shown result belongs to the latest request.
	a_status_matches_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pending_q == 2'd1) |->
		((pending_req_q == stbs_pkg::REQ_SEARCH) ==
		 (status == stbs_pkg::STATUS_FOUND || status == stbs_pkg::STATUS_MISSING)))
		else $error("result status does not match the kind of request");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(index))
		else $error("stalled result changed or dropped");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the sorted table binary search core
// A clocked driver offers append and search requests in bursts from a request
// queue, and a clocked monitor checks every status and index against a
// predictor that keeps its own copy of the key table and the entry count.
// ----------------------------------------------------------------------------
module tb_top;

	// The default depth keeps every bit of the 10-bit index in play.
	localparam int Depth      = stbs_pkg::TableDepthDefault;
	// Number of requests in the run.
	localparam int NumItems   = 400;
	// Quiet cycles allowed before the run is declared hung. The longest
	// legitimate quiet stretch is the receiver hold-off plus one search.
	localparam int IdleLimit  = 5000;
	// Length of the long receiver hold-off and the result count that starts it.
	localparam int HoldCycles = 400;
	localparam int HoldAt     = 300;
	// Cycles to keep watching after the last result, for stray transfers.
	localparam int TailCycles = 40;

	// One request as the driver will present it. When drain_first is set, the
	// driver waits until every earlier request has been answered.
	typedef struct packed {
		logic                             req_type;
		logic signed [stbs_pkg::KeyW-1:0] key;
		logic                             drain_first;
	} request_t;

	// One answer the core is expected to give.
	typedef struct packed {
		logic [stbs_pkg::StatusW-1:0] status;
		logic [stbs_pkg::IndexW-1:0]  index;
	} response_t;

	// Clock, reset and the core's ports. Inputs start at known values so
	// nothing floats before the reset branch of the driver takes over.
	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_ready;
	logic                             req_type  = stbs_pkg::REQ_APPEND;
	logic signed [stbs_pkg::KeyW-1:0] key       = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [stbs_pkg::StatusW-1:0]     status;
	logic [stbs_pkg::IndexW-1:0]      index;

	// Stimulus and prediction state.
	request_t                         request_queue[$];
	response_t                        pending_responses[$];
	logic signed [stbs_pkg::KeyW-1:0] model_keys[Depth];
	int                               model_count;
	logic signed [stbs_pkg::KeyW-1:0] gen_keys[$];
	longint                           last_sorted;
	request_t                         next_req;

	// Counters. The two transfer counts are updated with nonblocking
	// assignments so that other processes see their pre-edge values.
	int n_accepted;
	int n_checked;
	int mismatches;
	int idle_cycles;

	// Sender burst shaping and receiver stall pattern.
	int burst_left;
	int gap_left;
	int hold_left;
	bit hold_done;
	int ready_mode;
	int mode_left;
	int phase_count;

	sorted_table_binary_search_core #(
		.TABLE_DEPTH (Depth)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.index     (index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Queue one request for the driver. Appends are mirrored in gen_keys so
	// that later searches can aim at keys that really sit in the table.
	task automatic queue_request(input logic rt,
			input logic signed [stbs_pkg::KeyW-1:0] k, input logic drain);
		request_t r;
		r.req_type    = rt;
		r.key         = k;
		r.drain_first = drain;
		request_queue.push_back(r);
		if (rt == stbs_pkg::REQ_APPEND && gen_keys.size() < Depth)
			gen_keys.push_back(k);
	endtask

	// Pick a search key: half the time a key that is stored, some just beside a
	// stored key, some anywhere in the 32-bit range, some at the extremes.
	function automatic logic signed [stbs_pkg::KeyW-1:0] pick_search_key();
		logic signed [stbs_pkg::KeyW-1:0] k;
		int                               pick;
		pick = $urandom_range(0, 7);
		if (gen_keys.size() == 0)
			pick = 5;
		case (pick)
			0, 1, 2, 3: begin
				k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
			end
			4: begin
				k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
				k = $urandom_range(0, 1) ? k + 1 : k - 1;
			end
			6: begin
				case ($urandom_range(0, 3))
					0:       k = 32'sh8000_0000;
					1:       k = 32'sh7fff_ffff;
					2:       k = '0;
					default: k = -1;
				endcase
			end
			default: begin
				k = $urandom;
			end
		endcase
		return k;
	endfunction

	// Next key of the well-formed ascending fill. The step is sized from the
	// slots still free, so the fill climbs steadily through the signed range;
	// a step of zero gives a duplicate.
	function automatic logic signed [stbs_pkg::KeyW-1:0] pick_sorted_key();
		longint remaining;
		longint step_max;
		remaining = Depth - gen_keys.size();
		if (remaining <= 1) begin
			last_sorted = 64'sd2147483647;
		end else if ($urandom_range(0, 15) != 0) begin
			step_max = (64'sd2147483647 - last_sorted) / remaining * 2;
			if (step_max > 64'sh0_ffff_ffff)
				step_max = 64'sh0_ffff_ffff;
			last_sorted = last_sorted + longint'($urandom_range(0, int'(step_max)));
		end
		return last_sorted[stbs_pkg::KeyW-1:0];
	endfunction

	// Predictor: applies one accepted request to the bench's own copy of the
	// table and queues the answer. A search walks the classic probe sequence,
	// comparing keys as signed values and stopping at the first match, so
	// unsorted contents and duplicates give the same answer the core must.
	task automatic predict_table_response(input logic rt,
			input logic signed [stbs_pkg::KeyW-1:0] k);
		response_t r;
		int        lo;
		int        hi;
		int        mid;
		bit        done;
		r.status = stbs_pkg::STATUS_MISSING;
		r.index  = '0;
		if (rt == stbs_pkg::REQ_APPEND) begin
			if (model_count < Depth) begin
				model_keys[model_count] = k;
				r.status = stbs_pkg::STATUS_APPENDED;
				r.index  = model_count[stbs_pkg::IndexW-1:0];
				model_count++;
			end else begin
				r.status = stbs_pkg::STATUS_FULL;
			end
		end else begin
			lo   = 0;
			hi   = model_count - 1;
			done = 1'b0;
			while (!done && lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (model_keys[mid] == k) begin
					r.status = stbs_pkg::STATUS_FOUND;
					r.index  = mid[stbs_pkg::IndexW-1:0];
					done     = 1'b1;
				end else if (model_keys[mid] < k) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
		end
		pending_responses.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------
	// A transfer happens at an edge where in_valid and in_ready are both
	// high; the request is predicted right there, from the values still on
	// the pins. The next request is only put up once the current one has
	// gone, so valid and the payload never move while an offer is open.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			req_type    <= stbs_pkg::REQ_APPEND;
			key         <= '0;
			n_accepted  <= 0;
			burst_left  <= 0;
			gap_left    <= 0;
			model_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_table_response(req_type, key);
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0 &&
						(!request_queue[0].drain_first ||
						n_accepted + int'(in_valid && in_ready) == n_checked)) begin
					// A drain request goes out only once every earlier request
					// has been answered; the check may lag, never lead.
					next_req = request_queue.pop_front();
					in_valid <= 1'b1;
					req_type <= next_req.req_type;
					key      <= next_req.key;
					if (burst_left <= 1) begin
						// End of burst: a gap, often none, then a new burst.
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall pattern
	// ------------------------------------------------------------------
	// The receiver switches between always ready, coin-flip ready, mostly
	// stalled and a periodic pattern. Once, after HoldAt results, it holds
	// off for the long hold-off set by HoldCycles, so the core backs up and
	// stalls its input while the driver keeps offering.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			hold_left   <= 0;
			hold_done   <= 1'b0;
			ready_mode  <= 0;
			mode_left   <= 0;
			phase_count <= 0;
		end else begin
			phase_count <= phase_count + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && n_checked >= HoldAt) begin
				hold_done <= 1'b1;
				hold_left <= HoldCycles;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode <= $urandom_range(0, 3);
					mode_left  <= $urandom_range(16, 64);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (ready_mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= $urandom_range(0, 1);
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (phase_count[2:0] != 3'd0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------
	// Every result transfer is compared field by field with the oldest
	// answer still owed. A result with nothing owed is a failure too.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_checked <= 0;
		end else if (out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d index=%0d",
					status, index));
			end else begin
				if (status !== pending_responses[0].status)
					report_mismatch($sformatf("result %0d: status %0d, wanted %0d",
						n_checked, status, pending_responses[0].status));
				if (index !== pending_responses[0].index)
					report_mismatch($sformatf("result %0d: index %0d, wanted %0d",
						n_checked, index, pending_responses[0].index));
				void'(pending_responses.pop_front());
			end
			n_checked <= n_checked + 1;
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	// Counts cycles in which neither channel makes a transfer.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("Watchdog: no transfer for %0d cycles", IdleLimit);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		mismatches  = 0;
		idle_cycles = 0;

		// Directed part: searches on an empty table, the key extremes,
		// signed comparison across zero, and a duplicate key.
		queue_request(stbs_pkg::REQ_SEARCH, '0, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, 32'sh8000_0000, 1'b0);
		queue_request(stbs_pkg::REQ_APPEND, 32'sh8000_0000, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, 32'sh8000_0000, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, 32'sh7fff_ffff, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, -1, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, '0, 1'b0);
		queue_request(stbs_pkg::REQ_APPEND, 32'sh8000_0000, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, 32'sh8000_0000, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, 32'sh8000_0001, 1'b0);
		queue_request(stbs_pkg::REQ_APPEND, -7, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, -7, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, 7, 1'b0);
		queue_request(stbs_pkg::REQ_SEARCH, 32'sh7fff_ffff, 1'b0);
		last_sorted = -7;

		// Random part: an ascending fill with random steps and duplicates,
		// broken now and then by an out-of-order key, with searches mixed
		// in. Halfway through, the sender pauses until the core is empty.
		while (request_queue.size() < NumItems) begin
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 31) == 0)
					queue_request(stbs_pkg::REQ_APPEND, $urandom,
						request_queue.size() == NumItems / 2);
				else
					queue_request(stbs_pkg::REQ_APPEND, pick_sorted_key(),
						request_queue.size() == NumItems / 2);
			end else begin
				queue_request(stbs_pkg::REQ_SEARCH, pick_search_key(),
					request_queue.size() == NumItems / 2);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Sampled on the falling edge, once every update of the rising edge
		// has settled.
		do
			@(negedge clk);
		while (request_queue.size() != 0 || in_valid || pending_responses.size() != 0);
		repeat (TailCycles) @(negedge clk);

		if (pending_responses.size() != 0)
			report_mismatch($sformatf("%0d results never arrived",
				pending_responses.size()));
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
